// ===== rtl/core/fskm_pkg.sv =====
// ----------------------------------------------------------------------------
// fskm_pkg: shared types, constants and sine table builder
// Widths of the register and payload fields, register indexes, reset values
// and the elaboration-time functions that build the sine lookup table.
// ----------------------------------------------------------------------------
package fskm_pkg;

  // Payload and register widths
  localparam int SPB_W      = 13;
  localparam int AMP_W      = 15;
  localparam int HSTEP_W    = 21;
  localparam int CFG_DATA_W = 21;
  localparam int CFG_IDX_W  = 2;
  localparam int SAMPLE_W   = 16;
  localparam int BYTE_W     = 8;
  localparam int BITPOS_W   = 4;
  localparam int SAMPPOS_W  = 12;
  localparam int STEP_W     = HSTEP_W + 2;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_BIT_LEN   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_AMPLITUDE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_STEP = 2'd2;

  // Register reset values
  localparam logic [SPB_W-1:0]   SPB_RESET   = 13'd8;
  localparam logic [AMP_W-1:0]   AMP_RESET   = 15'd16384;
  localparam logic [HSTEP_W-1:0] HSTEP_RESET = 21'd1048576;

  // Bit length clamp
  localparam logic [SPB_W-1:0] SPB_MIN = 13'd1;
  localparam logic [SPB_W-1:0] SPB_MAX = 13'd4096;

  // Character framing: start bit, eight data bits, stop bit
  localparam logic [BITPOS_W-1:0] START_BIT = 4'd0;
  localparam logic [BITPOS_W-1:0] STOP_BIT  = 4'd9;

  // Queue depths
  localparam int CMD_QUEUE_DEPTH = 2;
  localparam int OUT_QUEUE_DEPTH = 4;

  // Sample rounding offset, half of 2^15
  localparam logic signed [31:0] ROUND_OFS = 32'sd16384;

  // pi/2 in Q60
  localparam logic [63:0] HALF_PI_Q60 = 64'h1921FB54442D1846;

  typedef struct packed {
    logic sample_valid;
    logic tone_active;
    logic char_done;
    logic load_accepted;
    logic ready_res;
  } fskm_flags_t;

  // floor(a*b / 2^60), 64-bit wrap as in a plain 64-bit datapath
  function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] al, ah, bl, bh, ll, lh, hl, hh, mid, lo, hi;
    al  = {32'd0, a[31:0]};
    ah  = {32'd0, a[63:32]};
    bl  = {32'd0, b[31:0]};
    bh  = {32'd0, b[63:32]};
    ll  = al * bl;
    lh  = al * bh;
    hl  = ah * bl;
    hh  = ah * bh;
    mid = (ll >> 32) + {32'd0, lh[31:0]} + {32'd0, hl[31:0]};
    lo  = {mid[31:0], ll[31:0]};
    hi  = hh + (lh >> 32) + (hl >> 32) + (mid >> 32);
    return (hi << 4) | (lo >> 60);
  endfunction

  // round(32767*sin(pi/2 * j/quarter)) via a Q60 Taylor series
  function automatic logic signed [SAMPLE_W-1:0] quarter_value(input int j, input int tbl_bits);
    logic [63:0] frac, x, x2, term, sum, t, scaled;
    frac = 64'(j) << (62 - tbl_bits);
    x    = mul_q60(HALF_PI_Q60, frac);
    x2   = mul_q60(x, x);
    term = x;
    sum  = x;
    for (int n = 1; n <= 9; n++) begin
      t = mul_q60(term, x2);
      unique case (n)
        1:       term = t / 64'd6;
        2:       term = t / 64'd20;
        3:       term = t / 64'd42;
        4:       term = t / 64'd72;
        5:       term = t / 64'd110;
        6:       term = t / 64'd156;
        7:       term = t / 64'd210;
        8:       term = t / 64'd272;
        default: term = t / 64'd342;
      endcase
      if ((n % 2) == 1) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    scaled = (((sum >> 20) * 64'd32767) + (64'd1 << 39)) >> 40;
    return SAMPLE_W'(scaled);
  endfunction

  // Full-period table entry built from quarter-wave symmetry
  function automatic logic signed [SAMPLE_W-1:0] wave_entry(input int k, input int tbl_bits);
    int size, quarter;
    size    = 1 << tbl_bits;
    quarter = size >> 2;
    if (k <= quarter) begin
      return quarter_value(k, tbl_bits);
    end else if (k <= 2 * quarter) begin
      return quarter_value(2 * quarter - k, tbl_bits);
    end else if (k <= 3 * quarter) begin
      return -quarter_value(k - 2 * quarter, tbl_bits);
    end else begin
      return -quarter_value(size - k, tbl_bits);
    end
  endfunction

endpackage

// ===== rtl/core/fskm_if.sv =====
// ----------------------------------------------------------------------------
// fskm_if: stream channels of the modulator
// Input channel carries commands (tick or byte load), output channel carries
// one result per command. Both use a valid/ready transfer.
// ----------------------------------------------------------------------------
interface fskm_in_if
  import fskm_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              action;
  logic [BYTE_W-1:0] data_byte;

  modport source (output valid, output action, output data_byte, input ready);
  modport sink   (input valid, input action, input data_byte, output ready);
endinterface

interface fskm_out_if
  import fskm_pkg::*;
();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       sample_valid;
  logic                       tone_active;
  logic                       char_done;
  logic                       load_accepted;
  logic                       ready_res;

  modport source (output valid, output sample, output sample_valid, output tone_active,
                  output char_done, output load_accepted, output ready_res, input ready);
  modport sink   (input valid, input sample, input sample_valid, input tone_active,
                  input char_done, input load_accepted, input ready_res, output ready);
endinterface

// ===== rtl/core/fskm_fifo.sv =====
// ----------------------------------------------------------------------------
// fskm_fifo: small register queue
// Power-of-two depth, first-word fall-through read, occupancy count output.
// ----------------------------------------------------------------------------
module fskm_fifo
  import fskm_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     push_i,
  input  logic [WIDTH-1:0]         push_data_i,
  input  logic                     pop_i,
  output logic [WIDTH-1:0]         pop_data_o,
  output logic                     empty_o,
  output logic                     full_o,
  output logic [$clog2(DEPTH):0]   count_o
);
  localparam int AW = $clog2(DEPTH);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [AW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [AW:0]      count_q, count_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + AW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + AW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + (AW + 1)'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - (AW + 1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign pop_data_o = mem_q[rd_ptr_q];
  assign empty_o    = (count_q == '0);
  assign full_o     = (count_q == (AW + 1)'(DEPTH));
  assign count_o    = count_q;
endmodule

// ===== rtl/core/fskm_front.sv =====
// ----------------------------------------------------------------------------
// fskm_front: command front end
// Holds the byte register and the character sequencer, advances the phase
// accumulator and emits a table index plus result flags per command.
// ----------------------------------------------------------------------------
module fskm_front
  import fskm_pkg::*;
#(
  parameter int PHASE_BITS      = 24,
  parameter int SINE_TABLE_BITS = 10
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       action_i,
  input  logic [BYTE_W-1:0]          data_byte_i,
  input  logic [SPB_W-1:0]           spb_i,
  input  logic [HSTEP_W-1:0]         half_step_i,
  input  logic                       queue_full_i,
  output logic                       push_o,
  output logic [SINE_TABLE_BITS-1:0] push_idx_o,
  output fskm_flags_t                push_flags_o
);
  logic [BYTE_W-1:0]     hold_byte_q, hold_byte_d;
  logic                  hold_full_q, hold_full_d;
  logic [BYTE_W-1:0]     shift_q, shift_d;
  logic [BITPOS_W-1:0]   bit_pos_q, bit_pos_d;
  logic [SAMPPOS_W-1:0]  samp_pos_q, samp_pos_d;
  logic [PHASE_BITS-1:0] phase_q, phase_d;
  logic                  sending_q, sending_d;

  logic                  accept;
  logic                  start;
  logic [BYTE_W-1:0]     shift_eff;
  logic [BITPOS_W-1:0]   bit_pos_eff;
  logic [SAMPPOS_W-1:0]  samp_pos_eff;
  logic                  cur_bit;
  logic [STEP_W-1:0]     init_w, step_w;
  logic [PHASE_BITS-1:0] phase_use;
  logic [SPB_W-1:0]      spb_eff;
  logic                  last_sample;
  fskm_flags_t           flags;

  assign accept     = in_valid_i && !queue_full_i;
  assign in_ready_o = !queue_full_i;

  // Character start on a tick that finds the sequencer idle with a byte waiting
  assign start        = !sending_q && hold_full_q;
  assign shift_eff    = start ? hold_byte_q : shift_q;
  assign bit_pos_eff  = start ? START_BIT : bit_pos_q;
  assign samp_pos_eff = start ? '0 : samp_pos_q;

  always_comb begin
    priority if (bit_pos_eff == START_BIT) begin
      cur_bit = 1'b0;
    end else if (bit_pos_eff < STOP_BIT) begin
      cur_bit = shift_eff[3'(bit_pos_eff - 4'd1)];
    end else begin
      cur_bit = 1'b1;
    end
  end

  // One sine cycle per bit for a 0, two for a 1: step is 2x or 4x half_step
  assign init_w    = cur_bit ? {1'b0, half_step_i, 1'b0} : {2'b00, half_step_i};
  assign step_w    = {init_w[STEP_W-2:0], 1'b0};
  assign phase_use = (samp_pos_eff == '0) ? PHASE_BITS'(init_w) : phase_q;

  always_comb begin
    priority if (spb_i == '0) begin
      spb_eff = SPB_MIN;
    end else if (spb_i > SPB_MAX) begin
      spb_eff = SPB_MAX;
    end else begin
      spb_eff = spb_i;
    end
  end

  assign last_sample = (({1'b0, samp_pos_eff} + SPB_W'(1)) >= spb_eff);

  always_comb begin
    hold_byte_d = hold_byte_q;
    hold_full_d = hold_full_q;
    shift_d     = shift_q;
    bit_pos_d   = bit_pos_q;
    samp_pos_d  = samp_pos_q;
    phase_d     = phase_q;
    sending_d   = sending_q;
    flags       = '0;
    if (accept) begin
      if (action_i) begin
        if (!hold_full_q) begin
          hold_byte_d         = data_byte_i;
          hold_full_d         = 1'b1;
          flags.load_accepted = 1'b1;
        end
      end else begin
        flags.sample_valid = 1'b1;
        if (start) begin
          shift_d     = hold_byte_q;
          hold_full_d = 1'b0;
        end
        if (sending_q || start) begin
          flags.tone_active = 1'b1;
          phase_d           = phase_use + PHASE_BITS'(step_w);
          if (last_sample) begin
            samp_pos_d = '0;
            if (bit_pos_eff == STOP_BIT) begin
              bit_pos_d       = START_BIT;
              sending_d       = 1'b0;
              flags.char_done = 1'b1;
            end else begin
              bit_pos_d = bit_pos_eff + BITPOS_W'(1);
              sending_d = 1'b1;
            end
          end else begin
            samp_pos_d = samp_pos_eff + SAMPPOS_W'(1);
            bit_pos_d  = bit_pos_eff;
            sending_d  = 1'b1;
          end
        end
      end
      flags.ready_res = !hold_full_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_byte_q <= '0;
      hold_full_q <= 1'b0;
      shift_q     <= '0;
      bit_pos_q   <= START_BIT;
      samp_pos_q  <= '0;
      phase_q     <= '0;
      sending_q   <= 1'b0;
    end else begin
      hold_byte_q <= hold_byte_d;
      hold_full_q <= hold_full_d;
      shift_q     <= shift_d;
      bit_pos_q   <= bit_pos_d;
      samp_pos_q  <= samp_pos_d;
      phase_q     <= phase_d;
      sending_q   <= sending_d;
    end
  end

  assign push_o       = accept;
  assign push_idx_o   = phase_use[PHASE_BITS-1 -: SINE_TABLE_BITS];
  assign push_flags_o = flags;
endmodule

// ===== rtl/core/fskm_back.sv =====
// ----------------------------------------------------------------------------
// fskm_back: sample synthesis back end
// Sine table read, amplitude scaling with rounding, and an output queue that
// parts the pipeline from the result channel. Pops only with room downstream.
// ----------------------------------------------------------------------------
module fskm_back
  import fskm_pkg::*;
#(
  parameter int SINE_TABLE_BITS = 10
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cmd_valid_i,
  input  logic [SINE_TABLE_BITS-1:0] cmd_idx_i,
  input  fskm_flags_t                cmd_flags_i,
  output logic                       cmd_pop_o,
  input  logic [AMP_W-1:0]           amplitude_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic signed [SAMPLE_W-1:0] out_sample_o,
  output fskm_flags_t                out_flags_o
);
  localparam int TBL_SIZE = 1 << SINE_TABLE_BITS;
  localparam int OUT_W    = SAMPLE_W + $bits(fskm_flags_t);
  localparam int CNT_W    = $clog2(OUT_QUEUE_DEPTH) + 1;

  typedef logic signed [SAMPLE_W-1:0] wave_rom_t [TBL_SIZE];

  function automatic wave_rom_t build_rom();
    wave_rom_t rom;
    for (int k = 0; k < TBL_SIZE; k++) begin
      rom[k] = wave_entry(k, SINE_TABLE_BITS);
    end
    return rom;
  endfunction

  localparam wave_rom_t WAVE_ROM = build_rom();

  logic                       va_q, vb_q;
  fskm_flags_t                flags_a_q, flags_b_q;
  logic signed [SAMPLE_W-1:0] rom_q;
  logic signed [31:0]         prod_q;
  logic signed [31:0]         prod_d;
  logic [CNT_W-1:0]           out_cnt;
  logic [CNT_W:0]             occupancy;
  logic                       out_empty, out_full;
  logic                       out_pop;
  logic signed [SAMPLE_W-1:0] push_sample;
  logic [OUT_W-1:0]           out_data;

  // Count entries already in the output queue and in flight to it
  assign occupancy = {1'b0, out_cnt} + (CNT_W + 1)'(va_q) + (CNT_W + 1)'(vb_q);
  assign cmd_pop_o = cmd_valid_i && (occupancy < (CNT_W + 1)'(OUT_QUEUE_DEPTH));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else begin
      va_q <= cmd_pop_o;
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    rom_q     <= WAVE_ROM[cmd_idx_i];
    flags_a_q <= cmd_flags_i;
    prod_q    <= prod_d;
    flags_b_q <= flags_a_q;
  end

  assign prod_d = $signed({1'b0, amplitude_i}) * rom_q + ROUND_OFS;

  // Arithmetic shift by 15 gives floor division on both signs
  assign push_sample = flags_b_q.tone_active ? prod_q[30:15] : '0;

  fskm_fifo #(
    .WIDTH (OUT_W),
    .DEPTH (OUT_QUEUE_DEPTH)
  ) u_out_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (vb_q),
    .push_data_i ({push_sample, flags_b_q}),
    .pop_i       (out_pop),
    .pop_data_o  (out_data),
    .empty_o     (out_empty),
    .full_o      (out_full),
    .count_o     (out_cnt)
  );

  assign out_valid_o  = !out_empty;
  assign out_pop      = out_valid_o && out_ready_i && !(out_full && 1'b0);
  assign out_sample_o = out_data[OUT_W-1 -: SAMPLE_W];
  assign out_flags_o  = out_data[$bits(fskm_flags_t)-1:0];
endmodule

// ===== rtl/core/fsk_uart_byte_modulator_unit.sv =====
// ----------------------------------------------------------------------------
// fsk_uart_byte_modulator_unit: binary FSK modulator for 8N1 UART bytes
// Turns byte loads and sample ticks into signed PCM samples, one result per
// command.
// ----------------------------------------------------------------------------
// Each command on the input channel is either a sample tick or a byte load,
// and each produces exactly one result on the output channel. A load stores
// the byte in a one-byte holding register (dropped and flagged if the register
// is still full). A tick that finds the sequencer idle with a byte waiting
// starts a character: start bit 0, eight data bits LSB first, stop bit 1, each
// as many ticks long as the bit length register gives and carrying one sine
// cycle for a 0 or two for a 1; idle ticks and loads return a zero sample.
// The block takes one command per clock cycle while the command queue has
// room and returns one result per cycle when the output side is ready; a
// result passes from its command transfer through the front end and queue,
// sine table read, amplitude multiply and output queue. The phase
// accumulator and bit sequencer in the front end settle each command in the
// cycle of its transfer, which sets the one-per-cycle rate. The sine table
// has 2^SINE_TABLE_BITS entries and is built at elaboration as a constant
// ROM, so there is no clearing pass after reset. Configuration writes are
// taken any cycle but should only be issued while no command is outstanding.
// ----------------------------------------------------------------------------
module fsk_uart_byte_modulator_unit
  import fskm_pkg::*;
#(
  parameter int PHASE_BITS      = 24,
  parameter int SINE_TABLE_BITS = 10
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  fskm_in_if.sink               in_if,
  fskm_out_if.source            out_if,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);
  localparam int CMD_W   = SINE_TABLE_BITS + $bits(fskm_flags_t);
  localparam int CMD_CNT = $clog2(CMD_QUEUE_DEPTH) + 1;

  // Configuration registers
  logic [SPB_W-1:0]   spb_q, spb_d;
  logic [AMP_W-1:0]   amp_q, amp_d;
  logic [HSTEP_W-1:0] hstep_q, hstep_d;

  // Front to back command queue
  logic                       push;
  logic [SINE_TABLE_BITS-1:0] push_idx;
  fskm_flags_t                push_flags;
  logic [CMD_W-1:0]           cmd_data;
  logic                       cmd_empty, cmd_full, cmd_pop;
  logic [CMD_CNT-1:0]         cmd_cnt;
  fskm_flags_t                out_flags;

  // Decode register writes; an index past the list is ignored
  always_comb begin
    spb_d   = spb_q;
    amp_d   = amp_q;
    hstep_d = hstep_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_BIT_LEN:   spb_d   = cfg_data_i[SPB_W-1:0];
        CFG_AMPLITUDE: amp_d   = cfg_data_i[AMP_W-1:0];
        CFG_HALF_STEP: hstep_d = cfg_data_i[HSTEP_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spb_q   <= SPB_RESET;
      amp_q   <= AMP_RESET;
      hstep_q <= HSTEP_RESET;
    end else begin
      spb_q   <= spb_d;
      amp_q   <= amp_d;
      hstep_q <= hstep_d;
    end
  end

  // Front end: take commands, sequence characters, advance phase
  fskm_front #(
    .PHASE_BITS      (PHASE_BITS),
    .SINE_TABLE_BITS (SINE_TABLE_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_if.valid),
    .in_ready_o   (in_if.ready),
    .action_i     (in_if.action),
    .data_byte_i  (in_if.data_byte),
    .spb_i        (spb_q),
    .half_step_i  (hstep_q),
    .queue_full_i (cmd_full),
    .push_o       (push),
    .push_idx_o   (push_idx),
    .push_flags_o (push_flags)
  );

  // Hold commands so the front keeps going while the back end waits
  fskm_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (CMD_QUEUE_DEPTH)
  ) u_cmd_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i ({push_idx, push_flags}),
    .pop_i       (cmd_pop),
    .pop_data_o  (cmd_data),
    .empty_o     (cmd_empty),
    .full_o      (cmd_full),
    .count_o     (cmd_cnt)
  );

  // Back end: table read, scale, buffer results for the output channel
  fskm_back #(
    .SINE_TABLE_BITS (SINE_TABLE_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (!cmd_empty && (cmd_cnt != '0)),
    .cmd_idx_i    (cmd_data[CMD_W-1 -: SINE_TABLE_BITS]),
    .cmd_flags_i  (cmd_data[$bits(fskm_flags_t)-1:0]),
    .cmd_pop_o    (cmd_pop),
    .amplitude_i  (amp_q),
    .out_valid_o  (out_if.valid),
    .out_ready_i  (out_if.ready),
    .out_sample_o (out_if.sample),
    .out_flags_o  (out_flags)
  );

  assign out_if.sample_valid  = out_flags.sample_valid;
  assign out_if.tone_active   = out_flags.tone_active;
  assign out_if.char_done     = out_flags.char_done;
  assign out_if.load_accepted = out_flags.load_accepted;
  assign out_if.ready_res     = out_flags.ready_res;
endmodule

// ===== rtl/core/fskm_checker.sv =====
// ----------------------------------------------------------------------------
// fskm_checker: port-level checks for the modulator
// Tracks commands in flight from the channel transfers and checks for
// phantom results, the in-flight bound and output channel stability.
// ----------------------------------------------------------------------------
module fskm_checker
  import fskm_pkg::*;
(
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_i,
  input logic                       out_valid_i,
  input logic                       out_ready_i,
  input logic signed [SAMPLE_W-1:0] out_sample_i,
  input logic                       out_sample_valid_i,
  input logic                       out_tone_active_i,
  input logic                       out_char_done_i,
  input logic                       out_load_accepted_i,
  input logic                       out_ready_res_i
);
  // Command queue, two pipeline stages, output queue
  localparam int MAX_PENDING = CMD_QUEUE_DEPTH + 2 + OUT_QUEUE_DEPTH;
  localparam int PEND_W      = $clog2(MAX_PENDING + 1) + 1;

  logic              in_xfer, out_xfer;
  logic [PEND_W-1:0] pending_q, pending_d;

  assign in_xfer  = in_valid_i && in_ready_i;
  assign out_xfer = out_valid_i && out_ready_i;

  always_comb begin
    pending_d = pending_q;
    if (in_xfer && !out_xfer) begin
      pending_d = pending_q + PEND_W'(1);
    end else if (out_xfer && !in_xfer) begin
      pending_d = pending_q - PEND_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_d;
    end
  end

  // No result without a command transfer still owed one
  a_no_phantom_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (pending_q != '0))
    else $error("result offered with no command outstanding");

  // Commands in flight stay within queue and pipeline capacity
  a_bounded_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q <= PEND_W'(MAX_PENDING))
    else $error("more commands in flight than storage holds");

  a_out_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result withdrawn before transfer");

  a_out_payload_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_sample_i) && $stable(out_sample_valid_i)
      && $stable(out_tone_active_i) && $stable(out_char_done_i)
      && $stable(out_load_accepted_i) && $stable(out_ready_res_i))
    else $error("stalled result changed");
endmodule

bind fsk_uart_byte_modulator_unit fskm_checker u_fskm_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .in_valid_i          (in_if.valid),
  .in_ready_i          (in_if.ready),
  .out_valid_i         (out_if.valid),
  .out_ready_i         (out_if.ready),
  .out_sample_i        (out_if.sample),
  .out_sample_valid_i  (out_if.sample_valid),
  .out_tone_active_i   (out_if.tone_active),
  .out_char_done_i     (out_if.char_done),
  .out_load_accepted_i (out_if.load_accepted),
  .out_ready_res_i     (out_if.ready_res)
);
